// ----- design/ptpc_pkg.sv -----
// ----------------------------------------------------------------------------
// ptpc_pkg
// shared types, constants and the texel packing function of the palette
// to 16-bit texel converter
// ----------------------------------------------------------------------------
package ptpc_pkg;

	// palette geometry
	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int INDEX_W         = 8;
	localparam int RGB_W           = 24;
	localparam int TEXEL_W         = 16;

	// front to back queue, power of two depth
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// opcodes
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_CONVERT = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND   = 1'b1;

	// pixel formats
	localparam int FMT_W = 3;
	localparam logic [FMT_W-1:0] FMT_RGB565   = 3'd0;
	localparam logic [FMT_W-1:0] FMT_BGR565   = 3'd1;
	localparam logic [FMT_W-1:0] FMT_RGB555   = 3'd2;
	localparam logic [FMT_W-1:0] FMT_RGBA5551 = 3'd3;
	localparam logic [FMT_W-1:0] FMT_ARGB1555 = 3'd4;

	// classified word travelling from the front to the back
	typedef struct packed {
		logic              is_load;
		logic [PAL_AW-1:0] addr;
		logic [RGB_W-1:0]  rgb;
		logic              use_bg;   // transparent index in an alpha format
		logic              oob;      // convert index beyond the palette
	} ptpc_item_t;

	function automatic logic is_alpha_fmt(input logic [FMT_W-1:0] fmt);
		return (fmt == FMT_RGBA5551) || (fmt == FMT_ARGB1555);
	endfunction

	function automatic logic [TEXEL_W-1:0] pack_texel(
		input logic [FMT_W-1:0] fmt,
		input logic [RGB_W-1:0] rgb,
		input logic             alpha
	);
		logic [4:0]         r5;
		logic [4:0]         g5;
		logic [5:0]         g6;
		logic [4:0]         b5;
		logic [TEXEL_W-1:0] t;
		r5 = rgb[23:19];
		g6 = rgb[15:10];
		g5 = rgb[15:11];
		b5 = rgb[7:3];
		unique case (fmt)
			FMT_BGR565:   t = {b5, g6, r5};
			FMT_RGB555:   t = {1'b0, r5, g5, b5};
			FMT_RGBA5551: t = {r5, g5, b5, alpha};
			FMT_ARGB1555: t = {alpha, r5, g5, b5};
			default:      t = {r5, g6, b5};
		endcase
		return t;
	endfunction

endpackage

// ----- design/ptpc_ram.sv -----
// ----------------------------------------------------------------------------
// ptpc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ptpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/ptpc_front.sv -----
// ----------------------------------------------------------------------------
// ptpc_front
// input stage: accepts words, classifies them and hands them to the queue
// ----------------------------------------------------------------------------
module ptpc_front import ptpc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                opcode,
	input  logic [INDEX_W-1:0]  entry_index,
	input  logic [7:0]          red_in,
	input  logic [7:0]          green_in,
	input  logic [7:0]          blue_in,
	input  logic [FMT_W-1:0]    fmt,
	output logic                push,
	output ptpc_item_t          item,
	input  logic                q_full
);

	logic       valid_s1;
	ptpc_item_t item_s1;
	ptpc_item_t item_d;
	logic       accept;
	logic       drop;

	// out of range loads vanish here
	always_comb begin
		item_d.is_load = (opcode == OP_LOAD);
		item_d.addr    = entry_index[PAL_AW-1:0];
		item_d.rgb     = {red_in, green_in, blue_in};
		item_d.oob     = ({1'b0, entry_index} >= (INDEX_W+1)'(PALETTE_ENTRIES));
		item_d.use_bg  = (opcode == OP_CONVERT) && is_alpha_fmt(fmt) && (entry_index == '0);
		drop           = item_d.is_load && item_d.oob;
	end

	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !q_full;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= !drop;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ----- design/ptpc_queue.sv -----
// ----------------------------------------------------------------------------
// ptpc_queue
// short fifo of classified words between front and back
// ----------------------------------------------------------------------------
module ptpc_queue import ptpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ptpc_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output ptpc_item_t head
);

	ptpc_item_t          entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full      = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- design/ptpc_back.sv -----
// ----------------------------------------------------------------------------
// ptpc_back
// execution side: palette writes, palette reads and texel packing
// ----------------------------------------------------------------------------
module ptpc_back import ptpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  ptpc_item_t         head,
	output logic               pop,
	input  logic [FMT_W-1:0]   fmt,
	input  logic [RGB_W-1:0]   bg_colour,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [TEXEL_W-1:0] texel_out
);

	logic               valid_s1;
	logic               use_bg_s1;
	logic               oob_s1;
	logic               valid_s2;
	logic [TEXEL_W-1:0] texel_s2;
	logic               s1_ready;
	logic               s2_ready;
	logic               s1_move;
	logic               rd_go;
	logic               wr_go;
	logic [RGB_W-1:0]   rd_data;
	logic [RGB_W-1:0]   rgb_sel;

	assign s2_ready = !valid_s2 || !out_stall;
	assign s1_ready = !valid_s1 || s2_ready;
	assign s1_move  = valid_s1 && s2_ready;

	// loads retire at once, converts wait for room in the read stage
	assign wr_go = q_not_empty && head.is_load;
	assign rd_go = q_not_empty && !head.is_load && s1_ready;
	assign pop   = wr_go || rd_go;

	ptpc_ram #(
		.WIDTH (RGB_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (wr_go),
		.waddr (head.addr),
		.wdata (head.rgb),
		.re    (rd_go),
		.raddr (head.addr),
		.rdata (rd_data)
	);

	always_comb begin
		if (use_bg_s1) begin
			rgb_sel = bg_colour;
		end else if (oob_s1) begin
			rgb_sel = '0;
		end else begin
			rgb_sel = rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= rd_go;
			end
			if (s2_ready) begin
				valid_s2 <= s1_move;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_go) begin
			use_bg_s1 <= head.use_bg;
			oob_s1    <= head.oob;
		end
		if (s1_move) begin
			texel_s2 <= pack_texel(fmt, rgb_sel, !use_bg_s1);
		end
	end

	assign out_valid = valid_s2;
	assign texel_out = texel_s2;

endmodule

// ----- design/palette_to_16bit_pixel_converter_core.sv -----
// ----------------------------------------------------------------------------
// palette_to_16bit_pixel_converter_core
// color lookup table: 24-bit rgb palette to 16-bit texel
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): opcode 0 writes palette entry
//   entry_index with red_in, green_in, blue_in and gives no result; opcode 1
//   converts entry_index and gives one texel_out word on the output channel
//   (out_valid / out_stall). results leave in the order of their converts.
//   config channel (cfg_valid / cfg_ready, always ready): index 0 pixel
//   format (0 rgb565, 1 bgr565, 2 rgb555, 3 rgba5551, 4 argb1555, other
//   values rgb565), index 1 background colour for index 0 in alpha formats.
//   write config only while the block is idle.
//   a convert passes the front register, queue, palette read and pack
//   register in that order before it is first offered.
//   throughput: one word per cycle unless out_stall holds converts back,
//   set by the single queue pop; loads and converts share the same slot.
//   reset clears control state and both config registers; palette contents
//   stay undefined until written, no clearing pass is run.
//   a stalled output holds its texel; the queue and pipeline keep taking
//   words until they fill, then in_stall rises.
// ----------------------------------------------------------------------------
module palette_to_16bit_pixel_converter_core import ptpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// input words
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 opcode,
	input  logic [INDEX_W-1:0]   entry_index,
	input  logic [7:0]           red_in,
	input  logic [7:0]           green_in,
	input  logic [7:0]           blue_in,
	// result words
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [TEXEL_W-1:0]   texel_out,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RGB_W-1:0]     cfg_data
);

	logic [FMT_W-1:0] fmt_q;
	logic [RGB_W-1:0] bg_q;
	logic             push;
	ptpc_item_t       push_item;
	logic             q_full;
	logic             pop;
	logic             q_not_empty;
	ptpc_item_t       head;

	// config registers, writes always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RGB565;
			bg_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PIXEL_FORMAT: fmt_q <= cfg_data[FMT_W-1:0];
				REG_BACKGROUND:   bg_q  <= cfg_data;
				default:          ;
			endcase
		end
	end

	// front: accept and classify
	ptpc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.entry_index (entry_index),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.fmt         (fmt_q),
		.push        (push),
		.item        (push_item),
		.q_full      (q_full)
	);

	// decoupling queue
	ptpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	// back: palette access and packing
	ptpc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.fmt         (fmt_q),
		.bg_colour   (bg_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.texel_out   (texel_out)
	);

endmodule

// ----- design/ptpc_checker.sv -----
// ----------------------------------------------------------------------------
// ptpc_checker
// port level checks of the converter, attached by bind
// ----------------------------------------------------------------------------
module ptpc_checker import ptpc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 opcode,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [TEXEL_W-1:0]   texel_out,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);

	// front register, queue, read stage and output stage
	localparam int SLOTS = QUEUE_DEPTH + 3;
	localparam int CNT_W = $clog2(SLOTS + 1);

	logic [CNT_W-1:0] pending_q;
	logic             conv_in;
	logic             word_out;

	assign conv_in  = in_valid && !in_stall && (opcode == OP_CONVERT);
	assign word_out = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			unique case ({conv_in, word_out})
				2'b10:   pending_q <= pending_q + 1'b1;
				2'b01:   pending_q <= pending_q - 1'b1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(texel_out))
		else $error("stalled texel changed or vanished");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("texel offered with no convert outstanding");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == CNT_W'(SLOTS) |-> in_stall)
		else $error("input not stalled with all slots holding converts");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind palette_to_16bit_pixel_converter_core ptpc_checker u_ptpc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.opcode      (opcode),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.texel_out   (texel_out),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready)
);
